/* rtl/lsi_pkg.sv */
`default_nettype none
package lsi_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int T_BITS     = 24;
  localparam int LIM_BITS   = 16;
  localparam int N_COORDS   = 8;

  // Difference of two coordinates, product of two differences, cross product.
  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int XW = PW + 1;
  localparam int MW = XW;
  // Integer bits of the parameter beyond the fraction.
  localparam int SH = T_BITS - FRAC_BITS;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DW-1:0]         diff_t;
  typedef logic signed [PW-1:0]         prod_t;
  typedef logic signed [XW-1:0]         xprod_t;
  typedef logic [MW-1:0]                mag_t;
  typedef logic signed [T_BITS-1:0]     tpar_t;

  // One restoring divider lane: partial remainder, dividend bits still to
  // shift in, quotient bits so far, overflow and result sign.
  typedef struct packed {
    mag_t              rem;
    logic [T_BITS-1:0] feed;
    logic [T_BITS-1:0] quo;
    logic              sat;
    logic              neg;
  } lane_t;

  typedef struct packed {
    coord_t ps_x;
    coord_t ps_y;
    diff_t  pv_x;
    diff_t  pv_y;
    mag_t   den_mag;
    logic   par;
    logic   hit;
    lane_t  lane_p;
    lane_t  lane_q;
  } item_t;

  function automatic diff_t sub_c(coord_t a, coord_t b);
    return {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
  endfunction

  function automatic mag_t mag_of(xprod_t x);
    return x[XW-1] ? mag_t'(-x) : mag_t'(x);
  endfunction

  // One quotient bit of |num| * 2^FRAC_BITS / den.
  function automatic lane_t div_step(lane_t l, mag_t d);
    logic [MW:0] trial;
    logic [MW:0] diff;
    lane_t       o;
    o     = l;
    trial = {l.rem, l.feed[T_BITS-1]};
    diff  = trial - {1'b0, d};
    if (trial >= {1'b0, d}) begin
      o.rem = diff[MW-1:0];
      o.quo = {l.quo[T_BITS-2:0], 1'b1};
    end else begin
      o.rem = trial[MW-1:0];
      o.quo = {l.quo[T_BITS-2:0], 1'b0};
    end
    o.feed = {l.feed[T_BITS-2:0], 1'b0};
    return o;
  endfunction

  // Applies the sign and saturates to the signed T_BITS range; a parallel item gives zero.
  function automatic tpar_t sat_t(lane_t l, logic par);
    logic              big;
    logic [T_BITS-1:0] q;
    tpar_t             r;
    if (par) begin
      r = '0;
    end else if (l.neg) begin
      big = l.sat | (l.quo[T_BITS-1] & (|l.quo[T_BITS-2:0]));
      q   = big ? {1'b1, {(T_BITS-1){1'b0}}} : l.quo;
      r   = tpar_t'(-q);
    end else begin
      big = l.sat | l.quo[T_BITS-1];
      r   = big ? tpar_t'({1'b0, {(T_BITS-1){1'b1}}}) : tpar_t'(l.quo);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/line_segment_intersection.sv */
// Intersection of a clip segment with an other edge taken as an infinite line.
// Input channel in_*: one item per handshake, eight signed Q12.4 coordinates.
// Result channel out_*: one result item per input item, in order, carrying
// the hit and parallel flags, the intersection point and both line
// parameters in signed Q8.16 (saturated).
// Configuration channel cfg_*: writes the parallel limit; it is always ready
// and should be written only while no item is in flight.
// From acceptance to the result appearing on out_*, an item passes the
// registers for differences, products and cross products, the restoring
// divider (one quotient bit per stage), then saturation, the point multiply
// and the output register.
// Throughput is one item per cycle; the divider pipeline sets that figure.
// When the receiver stalls, the whole pipeline holds and in_tready drops,
// so nothing is lost or repeated. Reset clears all valid bits and the
// parallel limit to zero.
`default_nettype none
module line_segment_intersection (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // clip_start_x, clip_start_y, clip_end_x, clip_end_y,
  // other_start_x, other_start_y, other_end_x, other_end_y (16 bits each)
  input  wire logic [127:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // cross_x [15:0], cross_y [31:16], clip_t [55:32], other_t [79:56]
  output logic [79:0]       out_tdata,
  // hit [0], parallel [1]
  output logic [1:0]        out_tuser,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [15:0]  cfg_data
);
  import lsi_pkg::*;

  localparam int NST = T_BITS;

  logic                adv;
  logic [LIM_BITS-1:0] lim_r;

  logic  dv [NST+1];
  item_t di [NST+1];

  logic   hit, par;
  coord_t cx, cy;
  tpar_t  ct, ot;

  // The pipeline moves whenever the output register is empty or being read.
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r <= '0;
    end else if (cfg_valid) begin
      lim_r <= cfg_data;
    end
  end

  lsi_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_tvalid),
    .in_data   (in_tdata),
    .lim       (lim_r),
    .out_valid (dv[0]),
    .out_item  (di[0])
  );

  // Divider: one quotient bit of each parameter per stage, MSB first.
  for (genvar s = 0; s < NST; s++) begin : g_div
    lsi_div_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .in_valid  (dv[s]),
      .in_item   (di[s]),
      .out_valid (dv[s+1]),
      .out_item  (di[s+1])
    );
  end

  lsi_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (dv[NST]),
    .in_item   (di[NST]),
    .out_valid (out_tvalid),
    .hit       (hit),
    .parallel  (par),
    .cross_x   (cx),
    .cross_y   (cy),
    .clip_t    (ct),
    .other_t   (ot)
  );

  assign out_tdata = {ot, ct, cy, cx};
  assign out_tuser = {par, hit};

endmodule
`default_nettype wire

/* rtl/lsi_front.sv */
`default_nettype none
module lsi_front (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    adv,
  input  wire logic                                    in_valid,
  input  wire logic [lsi_pkg::N_COORDS*lsi_pkg::COORD_BITS-1:0] in_data,
  input  wire logic [lsi_pkg::LIM_BITS-1:0]            lim,
  output logic                                         out_valid,
  output lsi_pkg::item_t                               out_item
);
  import lsi_pkg::*;

  coord_t c [N_COORDS];

  // Stage 1: edge vectors and start offset.
  logic   v1_r;
  coord_t ps_x_r, ps_y_r;
  diff_t  pv_x_r, pv_y_r, qv_x_r, qv_y_r, d_x_r, d_y_r;
  // Stage 2: the six products.
  logic   v2_r;
  coord_t ps_x2_r, ps_y2_r;
  diff_t  pv_x2_r, pv_y2_r;
  prod_t  m_r [6];
  prod_t  m_nxt [6];
  // Stage 3: the three cross products.
  logic   v3_r;
  coord_t ps_x3_r, ps_y3_r;
  diff_t  pv_x3_r, pv_y3_r;
  xprod_t den_r, pnum_r, qnum_r;
  // Stage 4 into the divider.
  logic   v4_r;
  item_t  item_r, item_nxt;

  mag_t              dmag, pmag, qmag;
  logic [MW+SH-1:0]  dsh;

  always_comb begin
    for (int k = 0; k < N_COORDS; k++) begin
      c[k] = coord_t'(in_data[k*COORD_BITS +: COORD_BITS]);
    end
  end

  always_comb begin
    m_nxt[0] = pv_x_r * qv_y_r;
    m_nxt[1] = pv_y_r * qv_x_r;
    m_nxt[2] = d_x_r * qv_y_r;
    m_nxt[3] = d_y_r * qv_x_r;
    m_nxt[4] = d_x_r * pv_y_r;
    m_nxt[5] = d_y_r * pv_x_r;
  end

  always_comb begin
    dmag = mag_of(den_r);
    pmag = mag_of(pnum_r);
    qmag = mag_of(qnum_r);
    dsh  = {dmag, {SH{1'b0}}};
    item_nxt.ps_x    = ps_x3_r;
    item_nxt.ps_y    = ps_y3_r;
    item_nxt.pv_x    = pv_x3_r;
    item_nxt.pv_y    = pv_y3_r;
    item_nxt.den_mag = dmag;
    item_nxt.par     = (dmag <= mag_t'(lim)) || (den_r == '0);
    item_nxt.hit     = !item_nxt.par
                       && ((pnum_r == '0) || (pnum_r[XW-1] == den_r[XW-1]))
                       && (pmag <= dmag);
    item_nxt.lane_p.rem  = pmag >> SH;
    item_nxt.lane_p.feed = {pmag[SH-1:0], {FRAC_BITS{1'b0}}};
    item_nxt.lane_p.quo  = '0;
    item_nxt.lane_p.sat  = {pmag, {SH{1'b0}}} >= {{SH{1'b0}}, dsh[MW+SH-1:SH]} << SH
                           ? ({{SH{1'b0}}, pmag} >= dsh) : 1'b0;
    item_nxt.lane_p.neg  = pnum_r[XW-1] ^ den_r[XW-1];
    item_nxt.lane_q.rem  = qmag >> SH;
    item_nxt.lane_q.feed = {qmag[SH-1:0], {FRAC_BITS{1'b0}}};
    item_nxt.lane_q.quo  = '0;
    item_nxt.lane_q.sat  = ({{SH{1'b0}}, qmag} >= dsh);
    item_nxt.lane_q.neg  = qnum_r[XW-1] ^ den_r[XW-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ps_x_r  <= c[0];
      ps_y_r  <= c[1];
      pv_x_r  <= sub_c(c[2], c[0]);
      pv_y_r  <= sub_c(c[3], c[1]);
      qv_x_r  <= sub_c(c[6], c[4]);
      qv_y_r  <= sub_c(c[7], c[5]);
      d_x_r   <= sub_c(c[4], c[0]);
      d_y_r   <= sub_c(c[5], c[1]);
      ps_x2_r <= ps_x_r;
      ps_y2_r <= ps_y_r;
      pv_x2_r <= pv_x_r;
      pv_y2_r <= pv_y_r;
      for (int k = 0; k < 6; k++) begin
        m_r[k] <= m_nxt[k];
      end
      ps_x3_r <= ps_x2_r;
      ps_y3_r <= ps_y2_r;
      pv_x3_r <= pv_x2_r;
      pv_y3_r <= pv_y2_r;
      den_r   <= {m_r[0][PW-1], m_r[0]} - {m_r[1][PW-1], m_r[1]};
      pnum_r  <= {m_r[2][PW-1], m_r[2]} - {m_r[3][PW-1], m_r[3]};
      qnum_r  <= {m_r[4][PW-1], m_r[4]} - {m_r[5][PW-1], m_r[5]};
      item_r  <= item_nxt;
    end
  end

  assign out_valid = v4_r;
  assign out_item  = item_r;

endmodule
`default_nettype wire

/* rtl/lsi_div_stage.sv */
`default_nettype none
module lsi_div_stage (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           adv,
  input  wire logic           in_valid,
  input  wire lsi_pkg::item_t in_item,
  output logic                out_valid,
  output lsi_pkg::item_t      out_item
);
  import lsi_pkg::*;

  // One quotient bit for both parameters per stage.
  logic  valid_r;
  item_t item_r, item_nxt;

  always_comb begin
    item_nxt        = in_item;
    item_nxt.lane_p = div_step(in_item.lane_p, in_item.den_mag);
    item_nxt.lane_q = div_step(in_item.lane_q, in_item.den_mag);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule
`default_nettype wire

/* rtl/lsi_back.sv */
`default_nettype none
module lsi_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 adv,
  input  wire logic                 in_valid,
  input  wire lsi_pkg::item_t       in_item,
  output logic                      out_valid,
  output logic                      hit,
  output logic                      parallel,
  output lsi_pkg::coord_t           cross_x,
  output lsi_pkg::coord_t           cross_y,
  output lsi_pkg::tpar_t            clip_t,
  output lsi_pkg::tpar_t            other_t
);
  import lsi_pkg::*;

  localparam int MPW = T_BITS + DW;

  // Stage 1: signed, saturated parameters.
  logic   v1_r, hit1_r, par1_r;
  coord_t ps_x1_r, ps_y1_r;
  diff_t  pv_x1_r, pv_y1_r;
  tpar_t  tp1_r, tq1_r;
  // Stage 2: parameter times clip vector.
  logic   v2_r, hit2_r, par2_r;
  coord_t ps_x2_r, ps_y2_r;
  tpar_t  tp2_r, tq2_r;
  logic signed [MPW-1:0] mx_r, my_r;
  // Stage 3: output register.
  logic   v3_r, hit3_r, par3_r;
  coord_t cx_r, cy_r;
  tpar_t  tp3_r, tq3_r;

  logic signed [MPW-1:0] sx, sy;
  coord_t cx_nxt, cy_nxt;

  always_comb begin
    sx     = mx_r >>> FRAC_BITS;
    sy     = my_r >>> FRAC_BITS;
    cx_nxt = hit2_r ? coord_t'(ps_x2_r + sx[COORD_BITS-1:0]) : '0;
    cy_nxt = hit2_r ? coord_t'(ps_y2_r + sy[COORD_BITS-1:0]) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit1_r  <= in_item.hit;
      par1_r  <= in_item.par;
      ps_x1_r <= in_item.ps_x;
      ps_y1_r <= in_item.ps_y;
      pv_x1_r <= in_item.pv_x;
      pv_y1_r <= in_item.pv_y;
      tp1_r   <= sat_t(in_item.lane_p, in_item.par);
      tq1_r   <= sat_t(in_item.lane_q, in_item.par);
      hit2_r  <= hit1_r;
      par2_r  <= par1_r;
      ps_x2_r <= ps_x1_r;
      ps_y2_r <= ps_y1_r;
      tp2_r   <= tp1_r;
      tq2_r   <= tq1_r;
      mx_r    <= tp1_r * pv_x1_r;
      my_r    <= tp1_r * pv_y1_r;
      hit3_r  <= hit2_r;
      par3_r  <= par2_r;
      cx_r    <= cx_nxt;
      cy_r    <= cy_nxt;
      tp3_r   <= tp2_r;
      tq3_r   <= tq2_r;
    end
  end

  assign out_valid = v3_r;
  assign hit       = hit3_r;
  assign parallel  = par3_r;
  assign cross_x   = cx_r;
  assign cross_y   = cy_r;
  assign clip_t    = tp3_r;
  assign other_t   = tq3_r;

endmodule
`default_nettype wire
